/* hw/rtl/tgbb_pkg.sv */
`timescale 1ns / 1ps
package tgbb_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 152;
  localparam int CFG_INDEX_W = 2;

  // input opcodes (tuser bit 0)
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_START_MIN_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_MIN_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_MAX_X = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_MAX_Y = 2'd3;

  localparam logic signed [15:0] BOX_MIN_RST = 16'sh7FFF;
  localparam logic signed [15:0] BOX_MAX_RST = 16'sh8000;

  // character codes
  localparam logic [7:0] TAB_CODE   = 8'd9;
  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [8:0] END_CODE   = 9'd128;

  // pen, 6 fractional bits
  localparam int PEN_W = 22;
  localparam logic [PEN_W-1:0] PEN_MAX = 22'h3FFFFF;
  localparam logic [PEN_W-1:0] TAB_STOP0 = 22'(150 * 64);
  localparam logic [PEN_W-1:0] TAB_STOP1 = 22'(210 * 64);
  localparam logic [PEN_W-1:0] TAB_STOP2 = 22'(270 * 64);
  localparam logic [PEN_W-1:0] TAB_STOP3 = 22'(330 * 64);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_TAB,
    KIND_GLYPH,
    KIND_OTHER
  } kind_t;

  // one glyph table entry
  typedef struct packed {
    logic [8:0]         left;
    logic [8:0]         top;
    logic [8:0]         right;
    logic [8:0]         bottom;
    logic signed [15:0] off_x;
    logic signed [15:0] off_y;
    logic [15:0]        advance;
  } glyph_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic               start;
    logic signed [15:0] off_x;
    logic signed [9:0]  span_x;
    logic signed [15:0] quad_top;
    logic signed [15:0] quad_bottom;
    logic [15:0]        advance;
  } work_t;

  typedef struct packed {
    logic               quad_valid;
    logic [PEN_W-1:0]   pen_position;
    logic signed [15:0] quad_bottom;
    logic signed [15:0] quad_right;
    logic signed [15:0] quad_top;
    logic signed [15:0] quad_left;
    logic signed [15:0] box_max_y;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_min_x;
  } result_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

/* hw/rtl/tgbb_front.sv */
`timescale 1ns / 1ps
module tgbb_front #(
  parameter int GLYPH_COUNT = 96,
  parameter int ATLAS_SIZE  = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tgbb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [tgbb_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              push_valid,
  output tgbb_pkg::work_t                   push_data,
  input  logic                              q_full
);

  localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam logic [12:0] ATLAS_MAX = 13'(ATLAS_SIZE - 1);
  localparam logic [7:0]  COUNT     = 8'(GLYPH_COUNT);

  function automatic logic [8:0] atlas_clip(input logic [8:0] v);
    if ({4'b0, v} > ATLAS_MAX) begin
      atlas_clip = ATLAS_MAX[8:0];
    end else begin
      atlas_clip = v;
    end
  endfunction

  tgbb_pkg::glyph_t glyph_mem [GLYPH_COUNT];
  tgbb_pkg::glyph_t rd_r;
  tgbb_pkg::glyph_t wr_entry;

  logic               s1_v_r, s1_v_nxt;
  tgbb_pkg::kind_t    s1_kind_r, kind;
  logic               s1_start_r;

  logic        op, start;
  logic [7:0]  slot8, gidx8, code;
  logic        slot_ok, acc;

  // unpack the beat
  assign op    = in_tuser[0];
  assign start = in_tuser[1];
  assign slot8 = {1'b0, in_tdata[6:0]};
  assign code  = in_tdata[98:91];
  assign gidx8 = {1'b0, code[6:0]} - tgbb_pkg::FIRST_CODE;
  assign slot_ok = slot8 < COUNT;

  assign wr_entry.left    = atlas_clip(in_tdata[15:7]);
  assign wr_entry.top     = atlas_clip(in_tdata[24:16]);
  assign wr_entry.right   = atlas_clip(in_tdata[33:25]);
  assign wr_entry.bottom  = atlas_clip(in_tdata[42:34]);
  assign wr_entry.off_x   = in_tdata[58:43];
  assign wr_entry.off_y   = in_tdata[74:59];
  assign wr_entry.advance = in_tdata[90:75];

  always_comb begin
    if (op == tgbb_pkg::OP_LOAD) begin
      kind = tgbb_pkg::KIND_LOAD;
    end else if (code == tgbb_pkg::TAB_CODE) begin
      kind = tgbb_pkg::KIND_TAB;
    end else if (code >= tgbb_pkg::FIRST_CODE && {1'b0, code} < tgbb_pkg::END_CODE &&
                 gidx8 < COUNT) begin
      kind = tgbb_pkg::KIND_GLYPH;
    end else begin
      kind = tgbb_pkg::KIND_OTHER;
    end
  end

  assign in_tready  = !s1_v_r || !q_full;
  assign acc        = in_tvalid && in_tready;
  assign push_valid = s1_v_r && !q_full;

  always_comb begin
    if (acc) begin
      s1_v_nxt = 1'b1;
    end else if (push_valid) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  // glyph table, written by loads, read by measured glyphs
  always_ff @(posedge clk) begin
    if (acc && op == tgbb_pkg::OP_LOAD && slot_ok) begin
      glyph_mem[slot8[AW-1:0]] <= wr_entry;
    end
    if (acc && kind == tgbb_pkg::KIND_GLYPH) begin
      rd_r <= glyph_mem[gidx8[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind_r  <= kind;
      s1_start_r <= (op == tgbb_pkg::OP_MEASURE) ? start : 1'b0;
    end
  end

  // pen-independent part of the quad
  logic signed [16:0] neg_off_y;
  logic signed [10:0] ry;
  logic signed [11:0] qb;

  assign neg_off_y = -{rd_r.off_y[15], rd_r.off_y};
  assign ry        = neg_off_y[16:6];
  assign qb        = {ry[10], ry} - $signed({3'b0, rd_r.bottom}) + $signed({3'b0, rd_r.top});

  assign push_data.kind        = s1_kind_r;
  assign push_data.start       = s1_start_r;
  assign push_data.off_x       = rd_r.off_x;
  assign push_data.span_x      = $signed({1'b0, rd_r.right}) - $signed({1'b0, rd_r.left});
  assign push_data.quad_top    = {{5{ry[10]}}, ry};
  assign push_data.quad_bottom = {{4{qb[11]}}, qb};
  assign push_data.advance     = rd_r.advance;

endmodule

/* hw/rtl/tgbb_queue.sv */
`timescale 1ns / 1ps
module tgbb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tgbb_pkg::work_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output tgbb_pkg::work_t head_data
);

  tgbb_pkg::work_t slots [tgbb_pkg::QUEUE_DEPTH];

  logic [tgbb_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [tgbb_pkg::QPTR_W:0]   count_r, count_nxt;

  assign full       = count_r == (tgbb_pkg::QPTR_W + 1)'(tgbb_pkg::QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_data  = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/tgbb_back.sv */
`timescale 1ns / 1ps
module tgbb_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [tgbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [15:0]                         cfg_data,
  input  logic                                head_valid,
  input  tgbb_pkg::work_t                     head_data,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output tgbb_pkg::result_t                   out_result
);

  logic signed [15:0] start_min_x_r, start_min_y_r, start_max_x_r, start_max_y_r;
  logic signed [15:0] min_x_r, min_y_r, max_x_r, max_y_r;
  logic signed [15:0] min_x_nxt, min_y_nxt, max_x_nxt, max_y_nxt;
  logic [tgbb_pkg::PEN_W-1:0] pen_r, pen_nxt, pen_base;
  logic out_v_r;
  tgbb_pkg::result_t res_r, res_nxt;

  logic signed [15:0] bmin_x, bmin_y, bmax_x, bmax_y;
  logic signed [23:0] sum_x;
  logic signed [17:0] rx;
  logic signed [18:0] rxw;
  logic signed [15:0] q0, q1, q2, q3;
  logic [tgbb_pkg::PEN_W:0] pen_add;
  logic [tgbb_pkg::PEN_W-1:0] pen_tab;
  logic is_glyph;

  assign pop        = head_valid && (!out_v_r || out_tready);
  assign out_tvalid = out_v_r;
  assign out_result = res_r;

  // base state, string start restarts pen and box
  assign pen_base = head_data.start ? '0 : pen_r;
  assign bmin_x   = head_data.start ? start_min_x_r : min_x_r;
  assign bmin_y   = head_data.start ? start_min_y_r : min_y_r;
  assign bmax_x   = head_data.start ? start_max_x_r : max_x_r;
  assign bmax_y   = head_data.start ? start_max_y_r : max_y_r;

  // quad x from pen plus offset, floored
  assign sum_x = $signed({2'b0, pen_base}) + {{8{head_data.off_x[15]}}, head_data.off_x};
  assign rx    = sum_x[23:6];
  assign rxw   = {rx[17], rx} + {{9{head_data.span_x[9]}}, head_data.span_x};
  assign q0    = tgbb_pkg::sat16({rx[17], rx});
  assign q2    = tgbb_pkg::sat16(rxw);
  assign q1    = head_data.quad_top;
  assign q3    = head_data.quad_bottom;

  assign pen_add  = {1'b0, pen_base} + {7'b0, head_data.advance};
  assign is_glyph = head_data.kind == tgbb_pkg::KIND_GLYPH;

  always_comb begin
    if (pen_base < tgbb_pkg::TAB_STOP0) begin
      pen_tab = tgbb_pkg::TAB_STOP0;
    end else if (pen_base < tgbb_pkg::TAB_STOP1) begin
      pen_tab = tgbb_pkg::TAB_STOP1;
    end else if (pen_base < tgbb_pkg::TAB_STOP2) begin
      pen_tab = tgbb_pkg::TAB_STOP2;
    end else if (pen_base < tgbb_pkg::TAB_STOP3) begin
      pen_tab = tgbb_pkg::TAB_STOP3;
    end else begin
      pen_tab = pen_base;
    end
  end

  always_comb begin
    min_x_nxt = bmin_x;
    min_y_nxt = bmin_y;
    max_x_nxt = bmax_x;
    max_y_nxt = bmax_y;
    pen_nxt   = pen_base;
    case (head_data.kind)
      tgbb_pkg::KIND_LOAD: begin
        min_x_nxt = min_x_r;
        min_y_nxt = min_y_r;
        max_x_nxt = max_x_r;
        max_y_nxt = max_y_r;
        pen_nxt   = pen_r;
      end
      tgbb_pkg::KIND_TAB: begin
        pen_nxt = pen_tab;
      end
      tgbb_pkg::KIND_GLYPH: begin
        if (q0 < min_x_nxt) min_x_nxt = q0;
        if (q2 < min_x_nxt) min_x_nxt = q2;
        if (q1 < min_y_nxt) min_y_nxt = q1;
        if (q3 < min_y_nxt) min_y_nxt = q3;
        if (q0 > max_x_nxt) max_x_nxt = q0;
        if (q2 > max_x_nxt) max_x_nxt = q2;
        if (q1 > max_y_nxt) max_y_nxt = q1;
        if (q3 > max_y_nxt) max_y_nxt = q3;
        pen_nxt = pen_add[tgbb_pkg::PEN_W] ? tgbb_pkg::PEN_MAX : pen_add[tgbb_pkg::PEN_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_nxt.box_min_x    = min_x_nxt;
    res_nxt.box_min_y    = min_y_nxt;
    res_nxt.box_max_x    = max_x_nxt;
    res_nxt.box_max_y    = max_y_nxt;
    res_nxt.quad_left    = is_glyph ? q0 : '0;
    res_nxt.quad_top     = is_glyph ? q1 : '0;
    res_nxt.quad_right   = is_glyph ? q2 : '0;
    res_nxt.quad_bottom  = is_glyph ? q3 : '0;
    res_nxt.pen_position = pen_nxt;
    res_nxt.quad_valid   = is_glyph;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_min_x_r <= tgbb_pkg::BOX_MIN_RST;
      start_min_y_r <= tgbb_pkg::BOX_MIN_RST;
      start_max_x_r <= tgbb_pkg::BOX_MAX_RST;
      start_max_y_r <= tgbb_pkg::BOX_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tgbb_pkg::CFG_START_MIN_X: start_min_x_r <= cfg_data;
        tgbb_pkg::CFG_START_MIN_Y: start_min_y_r <= cfg_data;
        tgbb_pkg::CFG_START_MAX_X: start_max_x_r <= cfg_data;
        tgbb_pkg::CFG_START_MAX_Y: start_max_y_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= tgbb_pkg::BOX_MIN_RST;
      min_y_r <= tgbb_pkg::BOX_MIN_RST;
      max_x_r <= tgbb_pkg::BOX_MAX_RST;
      max_y_r <= tgbb_pkg::BOX_MAX_RST;
      pen_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (pop) begin
        min_x_r <= min_x_nxt;
        min_y_r <= min_y_nxt;
        max_x_r <= max_x_nxt;
        max_y_r <= max_y_nxt;
        pen_r   <= pen_nxt;
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* hw/rtl/text_glyph_bounding_box.sv */
`timescale 1ns / 1ps
// a result passes the front stage register, the queue and the output register before it is offered
// throughput: one item per cycle while out_tready is high, with a combinational pen and box update in the back end
// a 4-entry queue between the front end and the back end absorbs output stalls
// reset (rst_n, synchronous): pen to zero, box and start registers to their reset values
// the glyph table is not cleared by reset and holds garbage until loaded
module text_glyph_bounding_box #(
  parameter int GLYPH_COUNT = 96,
  parameter int ATLAS_SIZE  = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // glyph_slot[6:0], atlas_left[15:7], atlas_top[24:16], atlas_right[33:25],
  // atlas_bottom[42:34], offset_x[58:43], offset_y[74:59], advance[90:75],
  // char_code[98:91], zero fill[103:99]
  input  logic [tgbb_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op[0], string_start[1]
  input  logic [tgbb_pkg::IN_TUSER_W-1:0]     in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // box_min_x[15:0], box_min_y[31:16], box_max_x[47:32], box_max_y[63:48],
  // quad_left[79:64], quad_top[95:80], quad_right[111:96], quad_bottom[127:112],
  // pen_position[149:128], quad_valid[150], zero fill[151]
  output logic [tgbb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tgbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [15:0]                         cfg_data
);

  // front to queue
  logic            push_valid;
  tgbb_pkg::work_t push_data;
  logic            q_full;

  // queue to back
  logic            head_valid;
  tgbb_pkg::work_t head_data;
  logic            pop;

  tgbb_pkg::result_t result;

  // start registers are always writable
  assign cfg_ready = 1'b1;

  // front: classifies each beat, owns the glyph table, does the pen-free quad math
  tgbb_front #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .ATLAS_SIZE (ATLAS_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push_valid(push_valid),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // short queue so front and back stall independently
  tgbb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_data (head_data)
  );

  // back: pen and box state, quad x, output register
  tgbb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head_valid(head_valid),
    .head_data (head_data),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_result(result)
  );

  // pack the result beat, first field lowest
  assign out_tdata = {1'b0, result};

endmodule
